### hdl/ftks_pkg.sv
`timescale 1ns / 1ps
package ftks_pkg;

  localparam int TOP_ENTRIES_DEF = 8;
  localparam int NUM_TENANTS_DEF = 64;
  localparam int SLOT_W          = 6;

  typedef enum logic [1:0] {
    OC_INSERT   = 2'd0,
    OC_MERGE    = 2'd1,
    OC_REPLACE  = 2'd2,
    OC_NOT_KEPT = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_POST
  } state_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [7:0]  tenant;
    logic [15:0] packet_count;
    logic [23:0] byte_count;
  } rec_t;

  typedef struct packed {
    logic        accepted;
    logic [63:0] tenant_packet_total;
    logic [63:0] tenant_byte_total;
    outcome_t    flow_outcome;
    logic [5:0]  flow_slot;
    logic [63:0] flow_slot_packets;
    outcome_t    tenant_outcome;
    logic [5:0]  tenant_slot;
  } res_t;

  typedef struct packed {
    logic              found;
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       slot_pk;
    logic [63:0]       min_pk;
    logic [SLOT_W-1:0] min_slot;
  } search_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] fkey_a;
    logic [39:0] fkey_b;
    logic [7:0]  tid;
    logic [15:0] packets;
    logic [23:0] bytes;
    search_t     f;
    search_t     t;
  } probe_t;

  typedef struct packed {
    logic              fvalid;
    logic [SLOT_W-1:0] fslot;
    logic              tvalid;
    logic [SLOT_W-1:0] tslot;
    logic [63:0]       fkey_a;
    logic [39:0]       fkey_b;
    logic [7:0]        tid;
    logic [15:0]       packets;
    logic [23:0]       bytes;
  } repl_t;

  function automatic search_t search_step(input search_t s, input logic empty,
                                          input logic match, input logic [63:0] pk,
                                          input logic [15:0] packets,
                                          input logic [SLOT_W-1:0] idx);
    search_t r;
    r = s;
    if (!s.found) begin
      if (empty) begin
        r.found   = 1'b1;
        r.outcome = OC_INSERT;
        r.slot    = idx;
        r.slot_pk = 64'(packets);
      end else if (match) begin
        r.found   = 1'b1;
        r.outcome = OC_MERGE;
        r.slot    = idx;
        r.slot_pk = pk + 64'(packets);
      end else if (idx == '0 || pk < s.min_pk) begin
        r.min_pk   = pk;
        r.min_slot = idx;
      end
    end
    return r;
  endfunction

endpackage

### hdl/ftks_ram.sv
`timescale 1ns / 1ps
module ftks_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/ftks_cell.sv
`timescale 1ns / 1ps
module ftks_cell
  import ftks_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  probe_t probe_in,
  input  repl_t  repl,
  output probe_t probe_out
);

  logic [63:0] fkey_a;
  logic [39:0] fkey_b;
  logic [63:0] fpk;
  logic [63:0] fby;
  logic [7:0]  tkey;
  logic [63:0] tpk;
  logic [63:0] tby;

  search_t f_s;
  search_t t_s;
  logic    f_hit;
  logic    t_hit;

  always_comb begin
    f_s = search_step(probe_in.f, fpk == '0,
                      fkey_a == probe_in.fkey_a && fkey_b == probe_in.fkey_b,
                      fpk, probe_in.packets, SLOT_W'(IDX));
    t_s = search_step(probe_in.t, tpk == '0, tkey == probe_in.tid,
                      tpk, probe_in.packets, SLOT_W'(IDX));
    f_hit = probe_in.valid && f_s.found && !probe_in.f.found;
    t_hit = probe_in.valid && t_s.found && !probe_in.t.found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fkey_a <= '0;
      fkey_b <= '0;
      fpk    <= '0;
      fby    <= '0;
    end else if (repl.fvalid && repl.fslot == SLOT_W'(IDX)) begin
      fkey_a <= repl.fkey_a;
      fkey_b <= repl.fkey_b;
      fpk    <= 64'(repl.packets);
      fby    <= 64'(repl.bytes);
    end else if (f_hit) begin
      if (f_s.outcome == OC_MERGE) begin
        fpk <= fpk + 64'(probe_in.packets);
        fby <= fby + 64'(probe_in.bytes);
      end else begin
        fkey_a <= probe_in.fkey_a;
        fkey_b <= probe_in.fkey_b;
        fpk    <= 64'(probe_in.packets);
        fby    <= 64'(probe_in.bytes);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tkey <= '0;
      tpk  <= '0;
      tby  <= '0;
    end else if (repl.tvalid && repl.tslot == SLOT_W'(IDX)) begin
      tkey <= repl.tid;
      tpk  <= 64'(repl.packets);
      tby  <= 64'(repl.bytes);
    end else if (t_hit) begin
      if (t_s.outcome == OC_MERGE) begin
        tpk <= tpk + 64'(probe_in.packets);
        tby <= tby + 64'(probe_in.bytes);
      end else begin
        tkey <= probe_in.tid;
        tpk  <= 64'(probe_in.packets);
        tby  <= 64'(probe_in.bytes);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.fkey_a  <= probe_in.fkey_a;
    probe_out.fkey_b  <= probe_in.fkey_b;
    probe_out.tid     <= probe_in.tid;
    probe_out.packets <= probe_in.packets;
    probe_out.bytes   <= probe_in.bytes;
    probe_out.f       <= f_s;
    probe_out.t       <= t_s;
  end

endmodule

### hdl/flow_tenant_topk_stats_core.sv
`timescale 1ns / 1ps
// Per-tenant traffic totals with two top-K heavy-hitter tables (by flow, by tenant).
// Request channel rec_valid/rec_ready/rec carries one flow record; result channel
// res_valid/res_ready/res returns exactly one result per request, in order.
// A request whose tenant is not below NUM_TENANTS is answered as rejected
// without reading the totals memory or probing the tables, and changes no state.
// An accepted request reads the tenant totals memory while a probe walks the
// row of TOP_ENTRIES slot cells, one cell per cycle, updating the first empty or
// matching slot; after the last cell the minimum slot may be replaced.
// A result passes from acceptance through the launch register, the cell row and
// the pending result register to the output register; the next request is taken
// in the cycle after the result moves to the output register, so no request is
// taken while the previous one is still in the cell row or waiting in ST_POST.
// The output register holds a finished result while res_ready is low; the block
// takes and processes the next request meanwhile and holds its result until the
// output register frees up.
// Reset clears all totals (through per-tenant valid bits) and all table slots at
// once; no clearing pass is needed and rec_ready is high as soon as rst drops.
module flow_tenant_topk_stats_core
  import ftks_pkg::*;
#(
  parameter int TOP_ENTRIES = TOP_ENTRIES_DEF,
  parameter int NUM_TENANTS = NUM_TENANTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic rec_valid,
  output logic rec_ready,
  input  rec_t rec,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int TID_W = (NUM_TENANTS > 1) ? $clog2(NUM_TENANTS) : 1;

  state_t state;
  state_t state_next;

  logic accept;
  logic tid_ok;
  rec_t req;
  res_t pend;
  logic post_load;

  probe_t launch;
  probe_t chain [TOP_ENTRIES+1];
  probe_t ex;
  repl_t  repl;

  logic                   ram_re;
  logic                   ram_we;
  logic [TID_W-1:0]       ram_raddr;
  logic [TID_W-1:0]       ram_waddr;
  logic [127:0]           ram_rdata;
  logic [127:0]           ram_wdata;
  logic [NUM_TENANTS-1:0] tvalid;
  logic                   tot_known;
  logic [63:0]            pk_sum;
  logic [63:0]            by_sum;

  logic        f_repl;
  logic        t_repl;
  outcome_t    f_oc;
  outcome_t    t_oc;
  logic [5:0]  f_slot;
  logic [5:0]  t_slot;
  logic [63:0] f_pk;

  assign tid_ok    = {1'b0, rec.tenant} < 9'(NUM_TENANTS);
  assign accept    = rec_valid && rec_ready;
  assign ram_re    = accept && tid_ok;
  assign ram_raddr = rec.tenant[TID_W-1:0];
  assign ram_waddr = req.tenant[TID_W-1:0];
  assign pk_sum    = (tot_known ? ram_rdata[127:64] : 64'd0) + 64'(req.packet_count);
  assign by_sum    = (tot_known ? ram_rdata[63:0] : 64'd0) + 64'(req.byte_count);
  assign ram_wdata = {pk_sum, by_sum};

  ftks_ram #(
    .WIDTH(128),
    .DEPTH(NUM_TENANTS)
  ) u_totals (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
    end else if (ram_we) begin
      tvalid[ram_waddr] <= 1'b1;
    end
    if (ram_re) begin
      tot_known <= tvalid[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch.valid <= 1'b0;
    end else begin
      launch.valid <= accept && tid_ok;
    end
    launch.fkey_a  <= {rec.src_addr, rec.dst_addr};
    launch.fkey_b  <= {rec.sport, rec.dport, rec.proto};
    launch.tid     <= rec.tenant;
    launch.packets <= rec.packet_count;
    launch.bytes   <= rec.byte_count;
    launch.f       <= '0;
    launch.t       <= '0;
  end

  assign chain[0] = launch;

  for (genvar i = 0; i < TOP_ENTRIES; i++) begin : g_cell
    ftks_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe_in (chain[i]),
      .repl     (repl),
      .probe_out(chain[i+1])
    );
  end

  assign ex = chain[TOP_ENTRIES];

  always_comb begin
    f_repl = !ex.f.found && (64'(ex.packets) > ex.f.min_pk);
    t_repl = !ex.t.found && (64'(ex.packets) > ex.t.min_pk);
    if (ex.f.found) begin
      f_oc   = ex.f.outcome;
      f_slot = ex.f.slot;
      f_pk   = ex.f.slot_pk;
    end else if (f_repl) begin
      f_oc   = OC_REPLACE;
      f_slot = ex.f.min_slot;
      f_pk   = 64'(ex.packets);
    end else begin
      f_oc   = OC_NOT_KEPT;
      f_slot = '0;
      f_pk   = '0;
    end
    if (ex.t.found) begin
      t_oc   = ex.t.outcome;
      t_slot = ex.t.slot;
    end else if (t_repl) begin
      t_oc   = OC_REPLACE;
      t_slot = ex.t.min_slot;
    end else begin
      t_oc   = OC_NOT_KEPT;
      t_slot = '0;
    end
    repl.fvalid  = ex.valid && f_repl;
    repl.fslot   = ex.f.min_slot;
    repl.tvalid  = ex.valid && t_repl;
    repl.tslot   = ex.t.min_slot;
    repl.fkey_a  = ex.fkey_a;
    repl.fkey_b  = ex.fkey_b;
    repl.tid     = ex.tid;
    repl.packets = ex.packets;
    repl.bytes   = ex.bytes;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= rec;
    end
    if (accept && !tid_ok) begin
      pend.accepted            <= 1'b0;
      pend.tenant_packet_total <= '0;
      pend.tenant_byte_total   <= '0;
      pend.flow_outcome        <= OC_NOT_KEPT;
      pend.flow_slot           <= '0;
      pend.flow_slot_packets   <= '0;
      pend.tenant_outcome      <= OC_NOT_KEPT;
      pend.tenant_slot         <= '0;
    end
    if (ram_we) begin
      pend.accepted            <= 1'b1;
      pend.tenant_packet_total <= pk_sum;
      pend.tenant_byte_total   <= by_sum;
    end
    if (state == ST_SCAN && ex.valid) begin
      pend.flow_outcome      <= f_oc;
      pend.flow_slot         <= f_slot;
      pend.flow_slot_packets <= f_pk;
      pend.tenant_outcome    <= t_oc;
      pend.tenant_slot       <= t_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (post_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (post_load) begin
      res <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = tid_ok ? ST_READ : ST_POST;
        end
      end
      ST_READ: state_next = ST_SCAN;
      ST_SCAN: begin
        if (ex.valid) begin
          state_next = ST_POST;
        end
      end
      ST_POST: begin
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    rec_ready = 1'b0;
    ram_we    = 1'b0;
    post_load = 1'b0;
    case (state)
      ST_IDLE: rec_ready = !rst;
      ST_READ: ram_we = 1'b1;
      ST_SCAN: ;
      ST_POST: post_load = !res_valid || res_ready;
      default: ;
    endcase
  end

endmodule

### hdl/ftks_checker.sv
`timescale 1ns / 1ps
module ftks_checker
  import ftks_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rec_valid,
  input logic rec_ready,
  input rec_t rec,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_ready |=> !rec_ready)
    else $error("request taken while previous one in progress");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_reject_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.accepted |->
      res.flow_outcome == OC_NOT_KEPT && res.tenant_outcome == OC_NOT_KEPT &&
      res.tenant_packet_total == '0 && res.tenant_byte_total == '0)
    else $error("rejected request reports an update");

  a_not_kept_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.flow_outcome == OC_NOT_KEPT |->
      res.flow_slot == '0 && res.flow_slot_packets == '0)
    else $error("flow not kept but slot fields nonzero");

endmodule

bind flow_tenant_topk_stats_core ftks_checker u_ftks_checker (.*);
